@@ design/sal_pkg.sv @@
package sal_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = 10;
  localparam int LEN_W   = 11;
  localparam int KEY_W   = 11;
  localparam int SLOTS   = 2048;
  localparam int CNT_W   = 20;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_READ   = 1'b1;
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        symbol;
    logic              last;
    logic [ADDR_W-1:0] rank_index;
  } sal_in_t;

  typedef struct packed {
    logic              reply_kind;
    logic [ADDR_W-1:0] suffix_start;
    logic [ADDR_W-1:0] lcp_value;
    logic [LEN_W-1:0]  string_length;
    logic [CNT_W-1:0]  distinct_count;
    logic              overflow;
  } sal_out_t;

  // top -> build engine
  typedef struct packed {
    logic              start;
    logic              txt_we;
    logic [ADDR_W-1:0] txt_addr;
    logic [7:0]        txt_data;
    logic [ADDR_W-1:0] rd_index;
  } sal_ctl_t;

  // build engine -> top
  typedef struct packed {
    logic              done;
    logic              idle;
    logic [CNT_W-1:0]  total;
    logic [ADDR_W-1:0] ord_rd;
    logic [ADDR_W-1:0] pre_rd;
  } sal_sts_t;

endpackage

@@ design/sal_build.sv @@
module sal_build (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sal_pkg::sal_ctl_t        ctl,
  input  logic [sal_pkg::LEN_W-1:0] n,
  output sal_pkg::sal_sts_t        st
);
  import sal_pkg::*;

  typedef enum logic [27:0] {
    S_IDLE    = 28'h1 << 0,
    S_INIT_A  = 28'h1 << 1,
    S_INIT_B  = 28'h1 << 2,
    S_DBL_CHK = 28'h1 << 3,
    S_PAIR_A  = 28'h1 << 4,
    S_PAIR_B  = 28'h1 << 5,
    S_PAIR_C  = 28'h1 << 6,
    S_CLR     = 28'h1 << 7,
    S_SORT_A  = 28'h1 << 8,
    S_SORT_B  = 28'h1 << 9,
    S_SORT_C  = 28'h1 << 10,
    S_SORT_D  = 28'h1 << 11,
    S_SCAN_A  = 28'h1 << 12,
    S_SCAN_B  = 28'h1 << 13,
    S_RANK_A  = 28'h1 << 14,
    S_RANK_B  = 28'h1 << 15,
    S_RANK_C  = 28'h1 << 16,
    S_FIX     = 28'h1 << 17,
    S_INV_A   = 28'h1 << 18,
    S_INV_B   = 28'h1 << 19,
    S_KAS_A   = 28'h1 << 20,
    S_KAS_B   = 28'h1 << 21,
    S_KAS_C   = 28'h1 << 22,
    S_KAS_T   = 28'h1 << 23,
    S_KAS_U   = 28'h1 << 24,
    S_KAS_V   = 28'h1 << 25,
    S_KAS_W   = 28'h1 << 26,
    S_DONE    = 28'h1 << 27
  } sal_state_t;

  sal_state_t state_r, state_nxt;

  // memories
  logic [7:0]        txt_mem  [MAX_LEN];
  logic [ADDR_W-1:0] rank_mem [MAX_LEN];
  logic [ADDR_W-1:0] hi_mem   [MAX_LEN];
  logic [KEY_W-1:0]  lo_mem   [MAX_LEN];
  logic [ADDR_W-1:0] scr_mem  [MAX_LEN];
  logic [ADDR_W-1:0] ord_mem  [MAX_LEN];
  logic [LEN_W-1:0]  cnt_mem  [SLOTS];
  logic [ADDR_W-1:0] pre_mem  [MAX_LEN];

  logic [7:0]        txt_q;
  logic [ADDR_W-1:0] rank_q, hi_q, scr_q, ord_q, pre_q;
  logic [KEY_W-1:0]  lo_q;
  logic [LEN_W-1:0]  cnt_q;

  logic [ADDR_W-1:0] txt_ra, rank_ra, hl_ra, scr_ra, ord_ra, pre_ra;
  logic [KEY_W-1:0]  cnt_ra;
  logic              rank_we, pair_we, scr_we, ord_we, cnt_we, pre_we;
  logic [ADDR_W-1:0] rank_wa, pair_wa, scr_wa, ord_wa, pre_wa;
  logic [KEY_W-1:0]  cnt_wa;
  logic [ADDR_W-1:0] rank_wd, hi_wd, scr_wd, ord_wd, pre_wd;
  logic [KEY_W-1:0]  lo_wd;
  logic [LEN_W-1:0]  cnt_wd;

  always_ff @(posedge clk) begin
    if (ctl.txt_we) txt_mem[ctl.txt_addr] <= ctl.txt_data;
    txt_q <= txt_mem[txt_ra];
  end
  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    rank_q <= rank_mem[rank_ra];
  end
  always_ff @(posedge clk) begin
    if (pair_we) begin
      hi_mem[pair_wa] <= hi_wd;
      lo_mem[pair_wa] <= lo_wd;
    end
    hi_q <= hi_mem[hl_ra];
    lo_q <= lo_mem[hl_ra];
  end
  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_wa] <= scr_wd;
    scr_q <= scr_mem[scr_ra];
  end
  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_q <= ord_mem[ord_ra];
  end
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cnt_ra];
  end
  always_ff @(posedge clk) begin
    if (pre_we) pre_mem[pre_wa] <= pre_wd;
    pre_q <= pre_mem[pre_ra];
  end

  // sequencer registers
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0]  base_r, base_nxt;
  logic [KEY_W-1:0]  k_r, k_nxt;
  logic [LEN_W-1:0]  sum_r, sum_nxt;
  logic              pass_r, pass_nxt;
  logic              place_r, place_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [ADDR_W-1:0] hv_r, hv_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [ADDR_W-1:0] prev_hi_r, prev_hi_nxt;
  logic [KEY_W-1:0]  prev_lo_r, prev_lo_nxt;
  logic [ADDR_W-1:0] r_r, r_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt;
  logic [LEN_W-1:0]  l_r, l_nxt;
  logic [7:0]        c_r, c_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;

  logic [LEN_W-1:0]  n_m1, i_ext, i_base, i_l, p_l;
  logic              i_last;
  logic [ADDR_W-1:0] src_q;
  logic [KEY_W-1:0]  key_c;
  logic [2*LEN_W-1:0] tri_prod;

  assign n_m1     = n - LEN_W'(1);
  assign i_ext    = {1'b0, i_r};
  assign i_last   = (i_ext == n_m1);
  assign i_base   = i_ext + base_r;
  assign i_l      = i_ext + l_r;
  assign p_l      = {1'b0, p_r} + l_r;
  assign src_q    = pass_r ? ord_q : scr_q;
  assign key_c    = pass_r ? {1'b0, hi_q} : lo_q;
  assign tri_prod = n * (n + LEN_W'(1));

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    base_nxt    = base_r;
    k_nxt       = k_r;
    sum_nxt     = sum_r;
    pass_nxt    = pass_r;
    place_nxt   = place_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    hv_nxt      = hv_r;
    j_nxt       = j_r;
    prev_hi_nxt = prev_hi_r;
    prev_lo_nxt = prev_lo_r;
    r_nxt       = r_r;
    p_nxt       = p_r;
    l_nxt       = l_r;
    c_nxt       = c_r;
    total_nxt   = total_r;

    txt_ra  = i_r;
    rank_ra = i_r;
    hl_ra   = src_q;
    scr_ra  = i_r;
    ord_ra  = ctl.rd_index;
    pre_ra  = ctl.rd_index;
    cnt_ra  = k_r;

    rank_we = 1'b0; rank_wa = i_r;  rank_wd = '0;
    pair_we = 1'b0; pair_wa = i_r;  hi_wd = hv_r; lo_wd = '0;
    scr_we  = 1'b0; scr_wa  = i_r;  scr_wd = i_r;
    ord_we  = 1'b0; ord_wa  = i_r;  ord_wd = idx_r;
    cnt_we  = 1'b0; cnt_wa  = k_r;  cnt_wd = '0;
    pre_we  = 1'b0; pre_wa  = r_r;  pre_wd = l_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          i_nxt     = '0;
          base_nxt  = LEN_W'(1);
          state_nxt = S_INIT_A;
        end
      end
      S_INIT_A: state_nxt = S_INIT_B;
      S_INIT_B: begin
        rank_we = 1'b1;
        rank_wd = ADDR_W'(txt_q);
        i_nxt   = i_r + ADDR_W'(1);
        if (i_last) state_nxt = S_DBL_CHK;
        else state_nxt = S_INIT_A;
      end
      S_DBL_CHK: begin
        i_nxt = '0;
        if (base_r < n) state_nxt = S_PAIR_A;
        else state_nxt = S_FIX;
      end
      S_PAIR_A: state_nxt = S_PAIR_B;
      S_PAIR_B: begin
        hv_nxt    = rank_q;
        rank_ra   = i_base[ADDR_W-1:0];
        state_nxt = S_PAIR_C;
      end
      S_PAIR_C: begin
        pair_we = 1'b1;
        scr_we  = 1'b1;
        lo_wd   = (i_base < n) ? ({1'b0, rank_q} + KEY_W'(1)) : '0;
        i_nxt   = i_r + ADDR_W'(1);
        if (i_last) begin
          pass_nxt  = 1'b0;
          place_nxt = 1'b0;
          k_nxt     = '0;
          state_nxt = S_CLR;
        end else begin
          state_nxt = S_PAIR_A;
        end
      end
      S_CLR: begin
        cnt_we = 1'b1;
        k_nxt  = k_r + KEY_W'(1);
        i_nxt  = '0;
        if (&k_r) state_nxt = S_SORT_A;
      end
      // shared front half of histogram and placement
      S_SORT_A: begin
        ord_ra    = i_r;
        state_nxt = S_SORT_B;
      end
      S_SORT_B: begin
        idx_nxt   = src_q;
        state_nxt = S_SORT_C;
      end
      S_SORT_C: begin
        cnt_ra    = key_c;
        key_nxt   = key_c;
        state_nxt = S_SORT_D;
      end
      S_SORT_D: begin
        cnt_we = 1'b1;
        cnt_wa = key_r;
        cnt_wd = cnt_q + LEN_W'(1);
        if (place_r) begin
          ord_we = !pass_r;
          scr_we = pass_r;
          ord_wa = cnt_q[ADDR_W-1:0];
          scr_wa = cnt_q[ADDR_W-1:0];
          scr_wd = idx_r;
        end
        i_nxt = i_r + ADDR_W'(1);
        if (!i_last) begin
          state_nxt = S_SORT_A;
        end else if (!place_r) begin
          k_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = S_SCAN_A;
        end else if (!pass_r) begin
          pass_nxt  = 1'b1;
          place_nxt = 1'b0;
          k_nxt     = '0;
          state_nxt = S_CLR;
        end else begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_RANK_A;
        end
      end
      S_SCAN_A: state_nxt = S_SCAN_B;
      S_SCAN_B: begin
        cnt_we  = 1'b1;
        cnt_wd  = sum_r;
        sum_nxt = sum_r + cnt_q;
        k_nxt   = k_r + KEY_W'(1);
        if (&k_r) begin
          i_nxt     = '0;
          place_nxt = 1'b1;
          state_nxt = S_SORT_A;
        end else begin
          state_nxt = S_SCAN_A;
        end
      end
      S_RANK_A: state_nxt = S_RANK_B;
      S_RANK_B: begin
        idx_nxt   = scr_q;
        hl_ra     = scr_q;
        state_nxt = S_RANK_C;
      end
      S_RANK_C: begin
        if (i_r != '0 && (hi_q != prev_hi_r || lo_q != prev_lo_r)) begin
          j_nxt = j_r + ADDR_W'(1);
        end
        rank_we     = 1'b1;
        rank_wa     = idx_r;
        rank_wd     = j_nxt;
        prev_hi_nxt = hi_q;
        prev_lo_nxt = lo_q;
        i_nxt       = i_r + ADDR_W'(1);
        if (i_last) begin
          base_nxt  = base_r << 1;
          state_nxt = S_DBL_CHK;
        end else begin
          state_nxt = S_RANK_A;
        end
      end
      S_FIX: begin
        // a single suffix always has rank zero
        rank_we   = (n == LEN_W'(1));
        rank_wa   = '0;
        rank_wd   = '0;
        i_nxt     = '0;
        state_nxt = S_INV_A;
      end
      S_INV_A: state_nxt = S_INV_B;
      S_INV_B: begin
        ord_we = 1'b1;
        ord_wa = rank_q;
        ord_wd = i_r;
        i_nxt  = i_r + ADDR_W'(1);
        if (i_last) begin
          i_nxt     = '0;
          l_nxt     = '0;
          total_nxt = tri_prod[CNT_W:1];
          state_nxt = S_KAS_A;
        end else begin
          state_nxt = S_INV_A;
        end
      end
      S_KAS_A: state_nxt = S_KAS_B;
      S_KAS_B: begin
        r_nxt = rank_q;
        if (rank_q == '0) begin
          pre_we = 1'b1;
          pre_wa = '0;
          pre_wd = '0;
          l_nxt  = '0;
          i_nxt  = i_r + ADDR_W'(1);
          if (i_last) state_nxt = S_DONE;
          else state_nxt = S_KAS_A;
        end else begin
          ord_ra    = rank_q - ADDR_W'(1);
          state_nxt = S_KAS_C;
        end
      end
      S_KAS_C: begin
        p_nxt     = ord_q;
        state_nxt = S_KAS_T;
      end
      S_KAS_T: begin
        txt_ra = i_l[ADDR_W-1:0];
        if (i_l < n && p_l < n) state_nxt = S_KAS_U;
        else state_nxt = S_KAS_W;
      end
      S_KAS_U: begin
        c_nxt     = txt_q;
        txt_ra    = p_l[ADDR_W-1:0];
        state_nxt = S_KAS_V;
      end
      S_KAS_V: begin
        if (txt_q == c_r) begin
          l_nxt     = l_r + LEN_W'(1);
          state_nxt = S_KAS_T;
        end else begin
          state_nxt = S_KAS_W;
        end
      end
      S_KAS_W: begin
        pre_we    = 1'b1;
        total_nxt = total_r - CNT_W'(l_r);
        l_nxt     = (l_r != '0) ? l_r - LEN_W'(1) : '0;
        i_nxt     = i_r + ADDR_W'(1);
        if (i_last) state_nxt = S_DONE;
        else state_nxt = S_KAS_A;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      base_r  <= '0;
      k_r     <= '0;
      pass_r  <= 1'b0;
      place_r <= 1'b0;
      j_r     <= '0;
      l_r     <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      base_r  <= base_nxt;
      k_r     <= k_nxt;
      pass_r  <= pass_nxt;
      place_r <= place_nxt;
      j_r     <= j_nxt;
      l_r     <= l_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    hv_r      <= hv_nxt;
    prev_hi_r <= prev_hi_nxt;
    prev_lo_r <= prev_lo_nxt;
    r_r       <= r_nxt;
    p_r       <= p_nxt;
    c_r       <= c_nxt;
  end

  assign st.done   = (state_r == S_DONE);
  assign st.idle   = (state_r == S_IDLE);
  assign st.total  = total_r;
  assign st.ord_rd = ord_q;
  assign st.pre_rd = pre_q;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> state_r == S_IDLE) else $error("build start while engine busy");
  a_stay_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !ctl.start) |=> state_r == S_IDLE)
    else $error("engine left idle without start");
  a_no_text_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.txt_we |-> state_r == S_IDLE) else $error("text written during build");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    st.done |=> !st.done) else $error("done longer than one cycle");

endmodule

@@ design/suffix_array_lcp_builder_core.sv @@
// Loads a string one byte per cycle while busy is low (append transactions),
// then builds the suffix array by prefix doubling with two counting-sort
// passes per round and the LCP array in Kasai order, all on one-read
// one-write memories under one sequencer. Appends and reads are accepted one
// per cycle while busy is low; a read reply appears in the cycle after its
// transaction. An append marked last holds busy high for the build: R =
// ceil(log2 n) doubling rounds for n bytes, then the Kasai walk with at most
// 2n matched bytes. The four 2048-slot count sweeps per round and the
// per-element memory read chains make up most of the build. The summary
// reply is registered in the cycle after the build's done state.
// The result strobe out_valid is one cycle wide and cannot be held off.
module suffix_array_lcp_builder_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sal_pkg::sal_in_t  in_data,
  output logic              out_valid,
  output sal_pkg::sal_out_t out_data
);
  import sal_pkg::*;

  sal_ctl_t ctl;
  sal_sts_t st;

  logic              busy_r;
  logic              built_r;
  logic [LEN_W-1:0]  count_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  total_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic              out_hit_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_ovf_r;

  logic              accept, app_acc, rd_acc, room, rd_hit;
  logic [LEN_W-1:0]  eff_count;

  assign busy      = busy_r || !st.idle;
  assign accept    = start && !busy;
  assign app_acc   = accept && (in_data.req_type == REQ_APPEND);
  assign rd_acc    = accept && (in_data.req_type == REQ_READ);
  assign eff_count = built_r ? '0 : count_r;
  assign room      = (eff_count < LEN_W'(MAX_LEN));
  assign rd_hit    = built_r && ({1'b0, in_data.rank_index} < count_r);

  assign ctl.start    = app_acc && in_data.last;
  assign ctl.txt_we   = app_acc && room;
  assign ctl.txt_addr = eff_count[ADDR_W-1:0];
  assign ctl.txt_data = in_data.symbol;
  assign ctl.rd_index = in_data.rank_index;

  sal_build u_build (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .n     (count_r),
    .st    (st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      built_r     <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (app_acc) begin
        // first append after a build opens a new string
        built_r <= 1'b0;
        if (built_r) begin
          total_r <= '0;
          ovf_r   <= 1'b0;
        end
        if (room) count_r <= eff_count + LEN_W'(1);
        else begin
          count_r <= eff_count;
          ovf_r   <= 1'b1;
        end
        if (in_data.last) busy_r <= 1'b1;
      end
      if (rd_acc) out_valid_r <= 1'b1;
      if (st.done) begin
        busy_r      <= 1'b0;
        built_r     <= 1'b1;
        total_r     <= st.total;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st.done) begin
      out_kind_r <= KIND_SUMMARY;
      out_hit_r  <= 1'b0;
      out_len_r  <= count_r;
      out_cnt_r  <= st.total;
      out_ovf_r  <= ovf_r;
    end else if (rd_acc) begin
      out_kind_r <= KIND_READ;
      out_hit_r  <= rd_hit;
      out_len_r  <= count_r;
      out_cnt_r  <= total_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_data.reply_kind      = out_kind_r;
  assign out_data.suffix_start    = out_hit_r ? st.ord_rd : '0;
  assign out_data.lcp_value       = out_hit_r ? st.pre_rd : '0;
  assign out_data.string_length   = out_len_r;
  assign out_data.distinct_count  = out_cnt_r;
  assign out_data.overflow        = out_ovf_r;

  a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy) else $error("no busy after build start");
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(rd_acc || st.done)) else $error("reply without cause");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st.done |-> busy_r) else $error("build finished while not pending");

endmodule

@@ tb/tb.sv @@
module tb;
  import sal_pkg::*;

  localparam int TARGET_ITEMS = 1550;
  localparam longint CYCLE_LIMIT = 6000000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  sal_in_t  in_data;
  logic     out_valid;
  sal_out_t out_data;

  suffix_array_lcp_builder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow of the block's string and its suffix/LCP arrays
  logic [7:0]        txt[MAX_LEN];
  logic [ADDR_W-1:0] sfx[MAX_LEN];
  logic [ADDR_W-1:0] lcp_arr[MAX_LEN];
  int                txt_len;
  logic              txt_ovf;
  logic [CNT_W-1:0]  substr_cnt;
  logic              is_built;

  sal_out_t reply_q[$];
  int       n_errors;
  int       n_items;
  int       n_replies;
  int       n_builds;
  int       idle_pct;
  longint   cycles;

  function automatic bit suffix_less(input int a, input int b);
    for (int k = 0; a + k < txt_len && b + k < txt_len; k++) begin
      if (txt[a+k] != txt[b+k]) return txt[a+k] < txt[b+k];
    end
    // the suffix that runs out first sorts first
    return a > b;
  endfunction

  function automatic void build_arrays();
    longint sum;
    int     j;
    int     m;
    int     cur;
    for (int i = 0; i < txt_len; i++) sfx[i] = ADDR_W'(i);
    for (int i = 1; i < txt_len; i++) begin
      cur = sfx[i];
      j = i - 1;
      while (j >= 0 && suffix_less(cur, sfx[j])) begin
        sfx[j+1] = sfx[j];
        j--;
      end
      sfx[j+1] = ADDR_W'(cur);
    end
    sum = longint'(txt_len) * (txt_len + 1) / 2;
    for (int r = 0; r < txt_len; r++) begin
      m = 0;
      if (r > 0) begin
        while (sfx[r] + m < txt_len && sfx[r-1] + m < txt_len &&
               txt[sfx[r]+m] == txt[sfx[r-1]+m]) m++;
      end
      lcp_arr[r] = ADDR_W'(m);
      sum -= m;
    end
    substr_cnt = CNT_W'(sum);
    is_built = 1'b1;
    n_builds++;
  endfunction

  function automatic void predict_reply(input sal_in_t it);
    sal_out_t r;
    r = '0;
    if (it.req_type == REQ_APPEND) begin
      if (is_built) begin
        txt_len = 0;
        txt_ovf = 1'b0;
        substr_cnt = '0;
        is_built = 1'b0;
      end
      if (txt_len < MAX_LEN) begin
        txt[txt_len] = it.symbol;
        txt_len++;
      end else begin
        txt_ovf = 1'b1;
      end
      if (!it.last) return;
      build_arrays();
      r.reply_kind = KIND_SUMMARY;
    end else begin
      r.reply_kind = KIND_READ;
      if (is_built && it.rank_index < txt_len) begin
        r.suffix_start = sfx[it.rank_index];
        r.lcp_value = lcp_arr[it.rank_index];
      end
    end
    r.string_length = LEN_W'(txt_len);
    r.distinct_count = substr_cnt;
    r.overflow = txt_ovf;
    reply_q.insert(reply_q.size(), r);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic issue(input sal_in_t it);
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    predict_reply(it);
    n_items++;
    idle_pct = (n_items / 130) % 4 == 1 ? 61 : (n_items / 130) % 4 == 3 ? 37 : 0;
    @(negedge clk);
  endtask

  function automatic sal_in_t mk(input logic rq, input logic [7:0] sym, input logic lst,
                                 input logic [ADDR_W-1:0] ri);
    sal_in_t it;
    it.req_type = rq;
    it.symbol = sym;
    it.last = lst;
    it.rank_index = ri;
    return it;
  endfunction

  always @(posedge clk) begin
    sal_out_t e;
    if (rst_n && out_valid) begin
      n_replies++;
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply %p", $time, out_data);
        n_errors++;
      end else begin
        e = reply_q.pop_front();
        if (out_data !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d replies outstanding", $time, reply_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  typedef struct {
    sal_in_t  it;
    bit       chk;
    sal_out_t exp;
  } stim_row_t;

  stim_row_t rows[$];

  task automatic add_row(input sal_in_t it, input bit chk, input sal_out_t exp);
    stim_row_t s;
    s.it = it;
    s.chk = chk;
    s.exp = exp;
    rows.insert(rows.size(), s);
  endtask

  initial begin
    int       len;
    int       nreads;
    int       alpha;
    logic [7:0] base_sym;
    sal_out_t x;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    txt_len = 0;
    txt_ovf = 1'b0;
    substr_cnt = '0;
    is_built = 1'b0;
    n_errors = 0;
    n_items = 0;
    n_replies = 0;
    n_builds = 0;
    idle_pct = 0;
    cycles = 0;

    // directed table: expected values typed where obvious
    x = '0; x.reply_kind = KIND_READ;
    add_row(mk(REQ_READ, 8'h00, 1'b0, 10'd0), 1, x);
    add_row(mk(REQ_READ, 8'hFF, 1'b1, 10'h3FF), 1, x);
    x = '0; x.reply_kind = KIND_SUMMARY; x.string_length = 1; x.distinct_count = 1;
    add_row(mk(REQ_APPEND, 8'h7A, 1'b1, 10'h3FF), 1, x);
    x.reply_kind = KIND_READ;
    add_row(mk(REQ_READ, 8'h00, 1'b0, 10'd0), 1, x);
    add_row(mk(REQ_READ, 8'h00, 1'b0, 10'd1), 1, x);
    add_row(mk(REQ_READ, 8'h00, 1'b0, 10'h3FF), 1, x);
    x = '0;
    add_row(mk(REQ_APPEND, 8'hFF, 1'b0, 10'h2AA), 0, x);
    // new string started: reads return zero suffix and LCP values until the build
    x.reply_kind = KIND_READ; x.string_length = 1;
    add_row(mk(REQ_READ, 8'h00, 1'b0, 10'd0), 1, x);
    add_row(mk(REQ_APPEND, 8'h00, 1'b0, 10'h155), 0, x);
    add_row(mk(REQ_APPEND, 8'hFF, 1'b0, 10'd0), 0, x);
    add_row(mk(REQ_APPEND, 8'h00, 1'b1, 10'd0), 0, x);
    for (int i = 0; i < 5; i++) add_row(mk(REQ_READ, 8'h00, 1'b0, ADDR_W'(i)), 0, x);
    for (int i = 0; i < 3; i++) add_row(mk(REQ_APPEND, 8'h61, 1'b0, 10'd0), 0, x);
    x = '0; x.reply_kind = KIND_SUMMARY; x.string_length = 4; x.distinct_count = 4;
    add_row(mk(REQ_APPEND, 8'h61, 1'b1, 10'd0), 1, x);
    for (int i = 0; i < 4; i++) add_row(mk(REQ_READ, 8'h00, 1'b0, ADDR_W'(i)), 0, x);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].chk && reply_q.size() == 0) begin
        // fall through: a checked row always produces a reply
      end
      issue(rows[i].it);
      if (rows[i].chk && reply_q.size() > 0 && reply_q[$] !== rows[i].exp) begin
        $display("%0t: table row %0d expected %p, predictor %p", $time, i,
                 rows[i].exp, reply_q[$]);
        n_errors++;
      end
    end

    // hold off until every reply has drained
    start <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);

    // full store: the extra symbol is dropped, its last mark still builds
    for (int i = 0; i <= MAX_LEN; i++)
      issue(mk(REQ_APPEND, 8'($urandom_range(255, 0)), i == MAX_LEN, 10'($urandom())));
    for (int i = 0; i < 30; i++)
      issue(mk(REQ_READ, 8'($urandom()), 1'($urandom()),
               i == 0 ? 10'h3FF : 10'($urandom())));

    while (n_items < TARGET_ITEMS) begin
      len = $urandom_range(9, 0) == 0 ? 1 : $urandom_range(24, 2);
      alpha = $urandom_range(3, 0) == 0 ? 256 : $urandom_range(4, 1);
      base_sym = 8'($urandom_range(255, 0));
      for (int i = 0; i < len; i++) begin
        issue(mk(REQ_APPEND, base_sym + 8'($urandom_range(alpha - 1, 0)), i == len - 1,
                 10'($urandom())));
        // noise: reads while the string is still open
        if ($urandom_range(19, 0) == 0)
          issue(mk(REQ_READ, 8'($urandom()), 1'($urandom()), 10'($urandom())));
      end
      nreads = $urandom_range(90, 30);
      for (int i = 0; i < nreads; i++)
        issue(mk(REQ_READ, 8'($urandom()), 1'($urandom()),
                 $urandom_range(7, 0) == 0 ? 10'($urandom()) : 10'($urandom_range(len, 0))));
    end
    start <= 1'b0;

    while (reply_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d transactions, %0d builds, %0d replies checked", n_items, n_builds,
             n_replies);
    $display("Covered empty and length-one strings, byte extremes, full store and reads");
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
